@@ src/rpfa_pkg.sv @@
// rpfa_pkg: types and constants shared by the page frame allocator modules.
// No dependencies.

package rpfa_pkg;

	localparam int FRAME_W  = 20;
	localparam int COUNT_W  = 16;

	localparam logic [FRAME_W-1:0] FRAME_MAX = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Register index as decoded from paddr[2]
	localparam logic REG_BASE_FRAME = 1'b0;
	localparam logic [FRAME_W-1:0] BASE_FRAME_RST = 20'h00100;

	typedef enum logic [1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_SHARE   = 2'd2,
		MODE_QUERY   = 2'd3
	} rpfa_mode_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_OOM    = 3'd1,
		ST_BELOW  = 3'd2,
		ST_BEYOND = 3'd3,
		ST_DOUBLE = 3'd4,
		ST_SAT    = 3'd5
	} rpfa_status_t;

	typedef struct packed {
		rpfa_mode_t         mode;
		logic [FRAME_W-1:0] frame;
	} rpfa_req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] result_frame;
		logic [COUNT_W-1:0] ref_count;
		rpfa_status_t       status;
	} rpfa_rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_step;
		logic load;
		logic rd_item;
		logic upd;
		logic range_err;
		logic scan_start;
		logic scan_step;
		logic alloc_hit;
		logic oom;
	} rpfa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic is_alloc;
		logic out_of_range;
		logic scan_hit;
		logic scan_none;
	} rpfa_stat_t;

endpackage

@@ src/refcounted_page_frame_allocator_core.sv @@
// refcounted_page_frame_allocator_core: top level, APB register and glue.
// Depends on rpfa_pkg, rpfa_ctrl and rpfa_dp.
//
//  channel   handshake                        payload
//  -------   ------------------------------   -----------------------------
//  item in   start & !busy                    req  (mode, frame)
//  item out  done, one cycle, no back-press   rsp  (result_frame, ref_count,
//                                                   status)
//  config    psel & penable & pwrite (APB)    pwdata -> base_frame
//
// After reset the count store is swept to zero, one entry a cycle: busy stays
// high throughout the sweep, during which config writes are still taken.
// Release, share and query pass through decode with a registered store read,
// then an update state that writes the new count back for release and share;
// an out-of-range frame returns to idle from decode. Allocate walks the store
// from the top, one entry a cycle through the single read port, until a free
// entry is found or none of the candidates is free.
// done rises in the cycle busy falls; the receiver cannot stall it.

module refcounted_page_frame_allocator_core import rpfa_pkg::*; #(
	parameter int FRAMES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// item port
	input  logic        start,
	input  rpfa_req_t   req,
	output logic        busy,
	output logic        done,
	output rpfa_rsp_t   rsp,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [FRAME_W-1:0] base_frame_q;
	logic               reg_wr;
	rpfa_cmd_t          cmd;
	rpfa_stat_t         stat;

	// only register index 0 exists; index taken from paddr[2]
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && (paddr[2] == REG_BASE_FRAME);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_frame_q <= BASE_FRAME_RST;
		end else if (reg_wr) begin
			base_frame_q <= pwdata[FRAME_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_BASE_FRAME) ?
		{{(32-FRAME_W){1'b0}}, base_frame_q} : '0;

	rpfa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	rpfa_dp #(
		.FRAMES (FRAMES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.base_frame (base_frame_q),
		.req        (req),
		.stat       (stat),
		.done       (done),
		.rsp        (rsp)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an item in flight");

endmodule

@@ src/rpfa_dp.sv @@
// rpfa_dp: count store, item registers, range check, scan pointers and result register.
// Depends on rpfa_pkg; driven by rpfa_ctrl.

module rpfa_dp import rpfa_pkg::*; #(
	parameter int FRAMES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rpfa_cmd_t          cmd,
	input  logic [FRAME_W-1:0] base_frame,
	input  rpfa_req_t          req,
	output rpfa_stat_t         stat,
	output logic               done,
	output rpfa_rsp_t          rsp
);

	localparam int IW = $clog2(FRAMES);
	localparam logic [IW-1:0]      LAST_IDX = IW'(FRAMES - 1);
	localparam logic [FRAME_W-1:0] FRAMES_F = FRAME_W'(FRAMES);
	localparam logic [FRAME_W-1:0] TOP_F    = FRAME_W'(FRAMES - 1);

	logic [COUNT_W-1:0] mem [FRAMES];
	logic [COUNT_W-1:0] rdata_q;

	rpfa_req_t    req_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] clr_idx_q;
	logic [IW-1:0] scan_idx_q;
	logic          scan_more_q;
	logic [IW-1:0] scan_idx_s1;
	logic          scan_vld_s1;
	logic          done_q;
	rpfa_rsp_t     rsp_q;

	logic [FRAME_W-1:0] off;
	logic [FRAME_W-1:0] room;
	logic               below;
	logic               beyond;
	logic [IW-1:0]      item_idx;
	logic [IW-1:0]      scan_top;
	logic               scan_hit;

	logic [COUNT_W-1:0] new_cnt;
	rpfa_status_t       new_st;
	logic               upd_we;

	logic               mem_we;
	logic [IW-1:0]      mem_waddr;
	logic [COUNT_W-1:0] mem_wdata;
	logic               mem_re;
	logic [IW-1:0]      mem_raddr;

	// range check against the managed window
	assign off      = req_q.frame - base_frame;
	assign below    = req_q.frame < base_frame;
	assign beyond   = !below && (off >= FRAMES_F);
	assign item_idx = off[IW-1:0];

	// highest entry that still has a 20-bit frame number
	assign room     = FRAME_MAX - base_frame;
	assign scan_top = (room < TOP_F) ? room[IW-1:0] : LAST_IDX;

	assign scan_hit = scan_vld_s1 && (rdata_q == '0);

	assign stat.clr_last     = (clr_idx_q == LAST_IDX);
	assign stat.is_alloc     = (req_q.mode == MODE_ALLOC);
	assign stat.out_of_range = below || beyond;
	assign stat.scan_hit     = scan_hit;
	assign stat.scan_none    = !scan_hit && !scan_more_q;

	always_comb begin
		new_cnt = rdata_q;
		new_st  = ST_OK;
		upd_we  = 1'b0;
		case (req_q.mode)
			MODE_RELEASE: begin
				if (rdata_q == '0) begin
					new_st = ST_DOUBLE;
				end else begin
					new_cnt = rdata_q - COUNT_W'(1);
					upd_we  = 1'b1;
				end
			end
			MODE_SHARE: begin
				if (rdata_q == COUNT_MAX) begin
					new_st = ST_SAT;
				end else begin
					new_cnt = rdata_q + COUNT_W'(1);
					upd_we  = 1'b1;
				end
			end
			default: begin
				new_cnt = rdata_q;
			end
		endcase
	end

	// single write port, single registered read port
	assign mem_we    = cmd.clr_step || (cmd.upd && upd_we) || cmd.alloc_hit;
	assign mem_waddr = cmd.clr_step ? clr_idx_q : (cmd.alloc_hit ? scan_idx_s1 : idx_q);
	assign mem_wdata = cmd.clr_step ? '0 : (cmd.alloc_hit ? COUNT_W'(1) : new_cnt);
	assign mem_re    = cmd.rd_item || cmd.scan_step;
	assign mem_raddr = cmd.scan_step ? scan_idx_q : item_idx;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.rd_item) begin
			idx_q <= item_idx;
		end
		if (cmd.scan_start) begin
			scan_idx_q <= scan_top;
		end else if (cmd.scan_step && scan_more_q) begin
			scan_idx_q <= scan_idx_q - IW'(1);
		end
		if (cmd.scan_step) begin
			scan_idx_s1 <= scan_idx_q;
		end
		if (cmd.range_err) begin
			rsp_q.result_frame <= req_q.frame;
			rsp_q.ref_count    <= '0;
			rsp_q.status       <= below ? ST_BELOW : ST_BEYOND;
		end else if (cmd.upd) begin
			rsp_q.result_frame <= req_q.frame;
			rsp_q.ref_count    <= new_cnt;
			rsp_q.status       <= new_st;
		end else if (cmd.alloc_hit) begin
			rsp_q.result_frame <= base_frame + {{(FRAME_W-IW){1'b0}}, scan_idx_s1};
			rsp_q.ref_count    <= COUNT_W'(1);
			rsp_q.status       <= ST_OK;
		end else if (cmd.oom) begin
			rsp_q.result_frame <= '0;
			rsp_q.ref_count    <= '0;
			rsp_q.status       <= ST_OOM;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q   <= '0;
			scan_more_q <= 1'b0;
			scan_vld_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_idx_q <= (clr_idx_q == LAST_IDX) ? '0 : clr_idx_q + IW'(1);
			end
			if (cmd.scan_start) begin
				scan_more_q <= 1'b1;
				scan_vld_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_vld_s1 <= scan_more_q;
				if (scan_idx_q == '0) begin
					scan_more_q <= 1'b0;
				end
			end
			done_q <= cmd.upd || cmd.range_err || cmd.alloc_hit || cmd.oom;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

@@ src/rpfa_ctrl.sv @@
// rpfa_ctrl: sequencer for clearing pass, item decode, count update and allocate scan.
// Depends on rpfa_pkg; drives rpfa_dp.

module rpfa_ctrl import rpfa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  rpfa_stat_t stat,
	output rpfa_cmd_t  cmd,
	output logic       busy
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_UPD,
		S_SCAN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.is_alloc) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else if (stat.out_of_range) begin
					cmd.range_err = 1'b1;
					state_d       = S_IDLE;
				end else begin
					cmd.rd_item = 1'b1;
					state_d     = S_UPD;
				end
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = S_IDLE;
			end
			S_SCAN: begin
				if (stat.scan_hit) begin
					cmd.alloc_hit = 1'b1;
					state_d       = S_IDLE;
				end else if (stat.scan_none) begin
					cmd.oom = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != S_IDLE))
		else $error("busy out of step with state");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy_q) |=> busy_q)
		else $error("busy not raised after an item was taken");

endmodule
